// ===== sv/dq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
// No dependencies; imported by dq_ctrl, dq_datapath, the top level and the testbench.
package dq_pkg;

    // Default sizes of the store
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the channels
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } dq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } dq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;        // item taken this cycle
        logic capture_read;  // RAM read data is valid this cycle
    } dq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic needs_read;    // presented item is a pop of a non-empty queue
    } dq_sts_t;

endpackage

// ===== sv/dq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== sv/dq_ctrl.sv =====
// Controller state machine of the double-ended queue.
// Depends on dq_pkg for the state, command and status types.
module dq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  dq_pkg::dq_sts_t  sts,
    output dq_pkg::dq_cmd_t  cmd
);
    import dq_pkg::*;

    dq_state_t state_reg, state_next;
    logic      take_item;

    assign take_item = s_valid && s_ready;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (take_item) begin
                    state_next = sts.needs_read ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (take_item) begin
                        state_next = sts.needs_read ? S_READ : S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive handshakes and datapath commands
    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        cmd.capture_read = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_READ: begin
                cmd.capture_read = 1'b1;
            end
            S_OUT: begin
                m_valid = 1'b1;
                s_ready = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.accept = s_valid && s_ready;
    end

endmodule

// ===== sv/dq_datapath.sv =====
// Datapath of the double-ended queue: ring pointers, element RAM and result register.
// Depends on dq_pkg and dq_ram.
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [dq_pkg::OP_W-1:0]             s_operation,
    input  logic signed [dq_pkg::VALUE_W-1:0]   s_push_value,
    output logic signed [dq_pkg::VALUE_W-1:0]   m_pop_value,
    output logic [dq_pkg::STATUS_W-1:0]         m_status,
    output logic [dq_pkg::OCC_W-1:0]            m_occupancy,
    input  dq_pkg::dq_cmd_t                     cmd,
    output dq_pkg::dq_sts_t                     sts
);
    import dq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((CNT_W > PTR_W) ? CNT_W : PTR_W) + 1;
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    logic [PTR_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_W-1:0]    pop_value_reg;
    dq_status_t            status_reg, status_next;
    logic [OCC_W-1:0]      occ_reg;

    dq_op_t                op;
    logic                  is_push, is_front, full, empty;
    logic [PTR_W-1:0]      front_dec, front_inc, back_idx, last_idx;
    logic [SUM_W-1:0]      back_sum, last_sum;
    logic                  ram_we, ram_re;
    logic [PTR_W-1:0]      ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    assign op       = dq_op_t'(s_operation);
    assign is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
    assign is_front = (op == OP_PUSH_FRONT) || (op == OP_POP_FRONT);
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    // Ring positions: one step around and the two ends
    assign front_dec = (front_reg == '0) ? LAST_PTR : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_PTR) ? '0 : front_reg + 1'b1;
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - 1'b1;
    assign back_idx  = (back_sum >= DEPTH_SUM) ? PTR_W'(back_sum - DEPTH_SUM)
                                               : PTR_W'(back_sum);
    assign last_idx  = (last_sum >= DEPTH_SUM) ? PTR_W'(last_sum - DEPTH_SUM)
                                               : PTR_W'(last_sum);

    assign sts.needs_read = !is_push && !empty;

    // Steer RAM accesses
    assign ram_we    = cmd.accept && is_push && !full;
    assign ram_waddr = is_front ? front_dec : back_idx;
    assign ram_wdata = DATA_WIDTH'($unsigned(s_push_value));
    assign ram_re    = cmd.accept && !is_push && !empty;
    assign ram_raddr = is_front ? front_reg : last_idx;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Compute pointer, count and status updates
    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        if (is_push) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                if (is_front) begin
                    front_next = front_dec;
                end
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                if (is_front) begin
                    front_next = front_inc;
                end
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Hold ring state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (cmd.accept) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Load result register
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pop_value_reg <= '0;
            status_reg    <= status_next;
            occ_reg       <= OCC_W'(count_next);
        end else if (cmd.capture_read) begin
            pop_value_reg <= VALUE_W'(ram_rdata);
        end
    end

    assign m_pop_value = pop_value_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

endmodule

// ===== sv/double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one item: s_operation selects
//   push front, push back, pop front or pop back; s_push_value is the
//   element for pushes and is ignored by pops.
//   Result channel (m_valid/m_ready) returns one item per input item:
//   m_pop_value (popped element, zero otherwise), m_status (done, pop of
//   an empty queue, push to a full queue) and m_occupancy after the item.
//   A refused push or an empty pop changes nothing.
//   A push or a failed pop shows its result in the cycle after it is
//   accepted; a successful pop goes through S_READ first, for the registered
//   read port of the element RAM.
//   Throughput: the next item is accepted in the same cycle the current
//   result is taken, so pushes run at one item per cycle while m_ready
//   stays high; a successful pop holds s_ready low while in S_READ.
//   Reset (aresetn low, synchronous) empties the queue; the element RAM
//   is not cleared and needs no clearing pass.
//   While a result waits and m_ready is low, the result holds and s_ready stays low.
module double_ended_queue_top #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dq_pkg::OP_W-1:0]           s_operation,
    input  logic signed [dq_pkg::VALUE_W-1:0] s_push_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dq_pkg::VALUE_W-1:0] m_pop_value,
    output logic [dq_pkg::STATUS_W-1:0]       m_status,
    output logic [dq_pkg::OCC_W-1:0]          m_occupancy
);
    import dq_pkg::*;

    dq_cmd_t cmd;
    dq_sts_t sts;

    dq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    dq_datapath #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_operation (s_operation),
        .s_push_value(s_push_value),
        .m_pop_value (m_pop_value),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .cmd         (cmd),
        .sts         (sts)
    );

    // A refused push reports a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_occupancy == OCC_W'(DEPTH)))
        else $error("full status with occupancy below depth");

    // An empty pop reports zero data and zero occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_occupancy == '0 && m_pop_value == '0))
        else $error("empty status with data or occupancy");

    // A push shows its result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_operation[1]) |=> m_valid)
        else $error("push result not presented after one cycle");

    // The unused status code never appears
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_DONE || m_status == ST_EMPTY || m_status == ST_FULL))
        else $error("undefined status code");

endmodule

// ===== bench/tb_double_ended_queue_top.sv =====
// Self-checking testbench for double_ended_queue_top: directed and random push/pop traffic
// with a ring-buffer predictor, random gaps on both channels and one long result stall.
// Depends on dq_pkg and the RTL of the block.
module tb_double_ended_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int HOLD_CYCLES   = 400;
    // Longest legal quiet stretch is the long hold; give it several times over
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 1190;

    typedef struct {
        logic [VALUE_W-1:0] pop_value;
        dq_status_t         status;
        logic [OCC_W-1:0]   occupancy;
    } deque_result_t;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } rx_pattern_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation = '0;
    logic signed [VALUE_W-1:0] s_push_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_pop_value;
    logic [STATUS_W-1:0]      m_status;
    logic [OCC_W-1:0]         m_occupancy;

    // Predictor state
    logic [VALUE_W-1:0] deque_store [DEPTH];
    int                 deque_front;
    int                 deque_count;

    deque_result_t expected_results [$];
    deque_result_t result_want;
    int            error_count;
    int            quiet_cycles;
    bit            hold_request;

    double_ended_queue_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status),
        .m_occupancy  (m_occupancy)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the ring model by one item and return what the block should answer
    task automatic predict_deque(input dq_op_t op, input logic [VALUE_W-1:0] value,
                                 output deque_result_t res);
        res.pop_value = '0;
        res.status    = ST_DONE;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (deque_count >= DEPTH) begin
                res.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
                deque_front = (deque_front + DEPTH - 1) % DEPTH;
                deque_store[deque_front] = value;
                deque_count++;
            end else begin
                deque_store[(deque_front + deque_count) % DEPTH] = value;
                deque_count++;
            end
        end else begin
            if (deque_count == 0) begin
                res.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
                res.pop_value = deque_store[deque_front];
                deque_front = (deque_front + 1) % DEPTH;
                deque_count--;
            end else begin
                res.pop_value = deque_store[(deque_front + deque_count - 1) % DEPTH];
                deque_count--;
            end
        end
        res.occupancy = deque_count[OCC_W-1:0];
    endtask

    // Offer one item and hold it until accepted; valid stays high on return
    task automatic send_item(input dq_op_t op, input logic [VALUE_W-1:0] value);
        deque_result_t res;
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_push_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_deque(op, value, res);
        expected_results.push_back(res);
    endtask

    // Drop valid for a number of cycles
    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pops on an empty queue, both ends
    task automatic test_empty_pops();
        send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_item(OP_POP_BACK, 32'h0000_0000);
        pause_sender(2);
    endtask

    // Fill from both ends, the first eight with fixed edge values, refuse pushes when full, then pop both ends
    task automatic test_fill_and_refuse();
        logic [VALUE_W-1:0] fill_values [8];
        fill_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE};
        for (int i = 0; i < DEPTH; i++) begin
            send_item((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                      (i < 8) ? fill_values[i] : $urandom);
        end
        send_item(OP_PUSH_FRONT, 32'h1234_5678);
        send_item(OP_PUSH_BACK, 32'h8765_4321);
        pause_sender(1);
        send_item(OP_POP_FRONT, $urandom);
        send_item(OP_POP_BACK, $urandom);
        pause_sender(3);
        send_item(OP_POP_FRONT, $urandom);
        send_item(OP_POP_BACK, $urandom);
        pause_sender(2);
    endtask

    // Stall the result channel for a long stretch while items keep coming
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
            end else begin
                send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
            end
        end
        pause_sender(2);
    endtask

    // Random traffic in bursts; the push share moves between phases so the
    // occupancy sweeps from empty to full
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned push_pct;
        int unsigned burst_left;
        bit          no_gaps;
        dq_op_t      op;
        push_pct   = 50;
        burst_left = 0;
        no_gaps    = 1'b0;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(0, 4))
                    0: push_pct = 5;
                    1: push_pct = 25;
                    2: push_pct = 50;
                    3: push_pct = 75;
                    default: push_pct = 95;
                endcase
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if (!no_gaps) begin
                    pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                              : $urandom_range(0, 4));
                end
            end
            burst_left--;
            if ($urandom_range(0, 99) < push_pct) begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            send_item(op, pick_value());
        end
        pause_sender(1);
    endtask

    // Receiver: long hold on request, otherwise a changing stall pattern
    initial begin
        rx_pattern_t pattern;
        int unsigned pattern_left;
        int unsigned ready_pct;
        int unsigned period;
        int unsigned on_cycles;
        int unsigned phase;
        pattern      = RX_ALWAYS;
        pattern_left = 0;
        ready_pct    = 50;
        period       = 2;
        on_cycles    = 1;
        phase        = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = rx_pattern_t'($urandom_range(0, 2));
                    pattern_left = $urandom_range(20, 200);
                    ready_pct    = $urandom_range(20, 90);
                    period       = $urandom_range(2, 6);
                    on_cycles    = $urandom_range(1, period - 1);
                end
                pattern_left--;
                phase++;
                case (pattern)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_RANDOM:   m_ready <= ($urandom_range(0, 99) < ready_pct);
                    default:     m_ready <= ((phase % period) < on_cycles);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: pop_value %0d status %0d occ %0d",
                       m_pop_value, m_status, m_occupancy);
                error_count++;
            end else begin
                result_want = expected_results.pop_front();
                if (m_pop_value !== result_want.pop_value) begin
                    $error("pop_value: expected %0d, actual %0d",
                           $signed(result_want.pop_value), m_pop_value);
                    error_count++;
                end
                if (m_status !== result_want.status) begin
                    $error("status: expected %0d, actual %0d", result_want.status, m_status);
                    error_count++;
                end
                if (m_occupancy !== result_want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           result_want.occupancy, m_occupancy);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        error_count  = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        deque_front  = 0;
        deque_count  = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_empty_pops();
        test_fill_and_refuse();
        test_result_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        // Drain outstanding results, then let the pipeline settle
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
